[design/ufm_pkg.sv]
// Shared types and constants of the union-find merge engine.
package ufm_pkg;

   // Width of node indices, set sizes and counts.
   localparam int NODE_W = 11;
   // Largest node index that an 11-bit field can carry.
   localparam int NODE_LIMIT = 2047;
   // Default store depth and node count after reset.
   localparam int MAX_NODES_DEFAULT = 1024;
   localparam int RESET_NODES = 1024;

   // One store entry: parent link and set size (size is meaningful at roots only).
   typedef struct packed {
      logic [NODE_W-1:0] parent;
      logic [NODE_W-1:0] size;
   } entry_type;

   // Write request from the sequencer to the store.
   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] node;
      entry_type         data;
   } store_wr_type;

endpackage

[design/ufm_if.sv]
// Channel interfaces of the union-find merge engine: join requests, results, node count writes.
interface ufm_req_if;
   import ufm_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;
   modport source (output valid, output node_a, output node_b, input ready);
   modport sink (input valid, input node_a, input node_b, output ready);
endinterface

interface ufm_rsp_if;
   import ufm_pkg::*;
   logic              valid;
   logic              ready;
   logic              joined;
   logic [NODE_W-1:0] root_after;
   logic [NODE_W-1:0] components;
   logic              bad_node;
   modport source (output valid, output joined, output root_after, output components,
                   output bad_node, input ready);
   modport sink (input valid, input joined, input root_after, input components,
                 input bad_node, output ready);
endinterface

interface ufm_csr_if;
   import ufm_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] node_count;
   modport source (output valid, output node_count, input ready);
   modport sink (input valid, input node_count, output ready);
endinterface

[design/ufm_store.sv]
// Node store: one-write, one-read synchronous memory with write-to-read forwarding.
module ufm_store #(
   parameter int ENTRIES = ufm_pkg::MAX_NODES_DEFAULT + 1,
   parameter int ADDR_W  = ufm_pkg::NODE_W
) (
   input  logic                   clock,
   input  ufm_pkg::store_wr_type  wr,
   input  logic [ufm_pkg::NODE_W-1:0] rd_node,
   output ufm_pkg::entry_type     rd_data
);
   import ufm_pkg::*;

   entry_type             mem [ENTRIES];
   entry_type             rd_ff;
   entry_type             fwd_data_ff;
   logic                  fwd_ff;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;

   assign wr_addr = wr.node[ADDR_W-1:0];
   assign rd_addr = rd_node[ADDR_W-1:0];

   // Write, read and note a same-address write for forwarding
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      rd_ff       <= mem[rd_addr];
      fwd_ff      <= wr.en && (wr_addr == rd_addr);
      fwd_data_ff <= wr.data;
   end

   // Hand back the newest value of the entry
   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

[design/union_find_merge_engine.sv]
// Top level of the union-find merge engine: join sequencer around the node store.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  req_bus  | in  | valid/ready          | node_a, node_b
//  rsp_bus  | out | valid/ready          | joined, root_after, components, bad_node
//  csr_bus  | in  | valid/ready (ready=1)| node_count
//
// A join walks node a to its root and compresses its path, then does the same for node b,
// one store read per step, then merges; path compression keeps walks short.
// Nodes that already share a root skip the merge (no link and no size update).
// An item with a bad node index goes straight to the result. One item is in work at a time.
// After reset and after each node_count write a clearing pass over nodes 1..node_count
// runs (1024 nodes after reset by default) during which no item is accepted.
// A result waits in the output register; a stalled result holds the next one in the sequencer.
module union_find_merge_engine #(
   parameter int MAX_NODES = ufm_pkg::MAX_NODES_DEFAULT
) (
   input logic clock,
   input logic reset,
   ufm_req_if.sink   req_bus,
   ufm_rsp_if.source rsp_bus,
   ufm_csr_if.sink   csr_bus
);
   import ufm_pkg::*;

   localparam int DEPTH       = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
   localparam int RESET_COUNT = (RESET_NODES < DEPTH) ? RESET_NODES : DEPTH;
   localparam int ADDR_W      = $clog2(DEPTH + 1);
   localparam logic [NODE_W-1:0] DEPTH_N = NODE_W'(DEPTH);
   localparam logic [NODE_W-1:0] RESET_N = NODE_W'(RESET_COUNT);
   localparam logic [NODE_W-1:0] ONE_N   = NODE_W'(1);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_FIND  = 7'b0000100,
      ST_COMP  = 7'b0001000,
      ST_MERGE = 7'b0010000,
      ST_GROW  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] node_count_ff, node_count_in;
   logic [NODE_W-1:0] count_ff, count_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              sel_ff, sel_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] start_ff, start_in;
   logic [NODE_W-1:0] node_b_ff, node_b_in;
   logic [NODE_W-1:0] root_a_ff, root_a_in;
   logic [NODE_W-1:0] size_a_ff, size_a_in;
   logic [NODE_W-1:0] root_b_ff, root_b_in;
   logic [NODE_W-1:0] size_b_ff, size_b_in;
   logic              res_joined_ff, res_joined_in;
   logic [NODE_W-1:0] res_root_ff, res_root_in;
   logic              res_bad_ff, res_bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_joined_ff, rsp_joined_in;
   logic [NODE_W-1:0] rsp_root_ff, rsp_root_in;
   logic [NODE_W-1:0] rsp_comp_ff, rsp_comp_in;
   logic              rsp_bad_ff, rsp_bad_in;

   store_wr_type      wr;
   logic [NODE_W-1:0] rd_node;
   entry_type         rd_data;

   logic              req_take;
   logic              req_bad;
   logic              phase_end;
   logic              rsp_load;
   logic [NODE_W-1:0] root_cur;
   logic [NODE_W-1:0] small_root, big_root, small_size;
   logic [NODE_W-1:0] size_sum;
   logic [NODE_W-1:0] csr_clamped;

   ufm_store #(
      .ENTRIES (DEPTH + 1),
      .ADDR_W  (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_node (rd_node),
      .rd_data (rd_data)
   );

   // Handshake and request checks; hold off items while the node count is written
   assign req_bus.ready = (state_ff == ST_IDLE) && !csr_bus.valid;
   assign csr_bus.ready = 1'b1;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign req_bad       = (req_bus.node_a == '0) || (req_bus.node_b == '0) ||
                          (req_bus.node_a > node_count_ff) || (req_bus.node_b > node_count_ff);

   // Clamp a written node count to 1..DEPTH
   always_comb begin
      csr_clamped = csr_bus.node_count;
      if (csr_bus.node_count == '0) begin
         csr_clamped = ONE_N;
      end else if (csr_bus.node_count > DEPTH_N) begin
         csr_clamped = DEPTH_N;
      end
   end

   // Merge operands: smaller set goes under larger, a under b on a tie
   assign root_cur   = sel_ff ? root_b_ff : root_a_ff;
   assign small_root = (size_a_ff > size_b_ff) ? root_b_ff : root_a_ff;
   assign big_root   = (size_a_ff > size_b_ff) ? root_a_ff : root_b_ff;
   assign small_size = (size_a_ff > size_b_ff) ? size_b_ff : size_a_ff;
   assign size_sum   = size_a_ff + size_b_ff;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // Sequence the walks, compression, merge and result
   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      sel_in        = sel_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      node_b_in     = node_b_ff;
      root_a_in     = root_a_ff;
      size_a_in     = size_a_ff;
      root_b_in     = root_b_ff;
      size_b_in     = size_b_ff;
      res_joined_in = res_joined_ff;
      res_root_in   = res_root_ff;
      res_bad_in    = res_bad_ff;
      phase_end     = 1'b0;
      rd_node       = cur_ff;
      wr.en         = 1'b0;
      wr.node       = cur_ff;
      wr.data       = '{parent: root_cur, size: rd_data.size};

      case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.node = clr_ff;
            wr.data = '{parent: clr_ff, size: ONE_N};
            if (clr_ff == node_count_ff) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ONE_N;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_bad) begin
                  res_bad_in    = 1'b1;
                  res_joined_in = 1'b0;
                  res_root_in   = '0;
                  state_in      = ST_DONE;
               end else begin
                  res_bad_in = 1'b0;
                  sel_in     = 1'b0;
                  start_in   = req_bus.node_a;
                  cur_in     = req_bus.node_a;
                  node_b_in  = req_bus.node_b;
                  rd_node    = req_bus.node_a;
                  state_in   = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (rd_data.parent == cur_ff) begin
               if (sel_ff) begin
                  root_b_in = cur_ff;
                  size_b_in = rd_data.size;
               end else begin
                  root_a_in = cur_ff;
                  size_a_in = rd_data.size;
               end
               if (start_ff != cur_ff) begin
                  cur_in   = start_ff;
                  rd_node  = start_ff;
                  state_in = ST_COMP;
               end else begin
                  phase_end = 1'b1;
               end
            end else begin
               cur_in  = rd_data.parent;
               rd_node = rd_data.parent;
            end
         end
         ST_COMP: begin
            // point this node straight at its root, then move to its old parent
            wr.en = 1'b1;
            if (rd_data.parent == root_cur) begin
               phase_end = 1'b1;
            end else begin
               cur_in  = rd_data.parent;
               rd_node = rd_data.parent;
            end
         end
         ST_MERGE: begin
            if (root_a_ff == root_b_ff) begin
               res_joined_in = 1'b0;
               res_root_in   = root_a_ff;
               state_in      = ST_DONE;
            end else begin
               wr.en    = 1'b1;
               wr.node  = small_root;
               wr.data  = '{parent: big_root, size: small_size};
               state_in = ST_GROW;
            end
         end
         ST_GROW: begin
            wr.en         = 1'b1;
            wr.node       = big_root;
            wr.data       = '{parent: big_root, size: size_sum};
            res_joined_in = 1'b1;
            res_root_in   = big_root;
            if (count_ff > ONE_N) begin
               count_in = count_ff - ONE_N;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move from node a's walk to node b's, or on to the merge
      if (phase_end) begin
         if (!sel_ff) begin
            sel_in   = 1'b1;
            start_in = node_b_ff;
            cur_in   = node_b_ff;
            rd_node  = node_b_ff;
            state_in = ST_FIND;
         end else begin
            state_in = ST_MERGE;
         end
      end

      // Restart the sets on a node count write
      if (csr_bus.valid) begin
         node_count_in = csr_clamped;
         count_in      = csr_clamped;
         clr_in        = ONE_N;
         state_in      = ST_CLEAR;
      end
   end

   // Load the output register, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_joined_in = rsp_joined_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_bad_in    = rsp_bad_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_joined_in = res_joined_ff;
         rsp_root_in   = res_root_ff;
         rsp_comp_in   = count_ff;
         rsp_bad_in    = res_bad_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= RESET_N;
         count_ff      <= RESET_N;
         clr_ff        <= ONE_N;
         sel_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         count_ff      <= count_in;
         clr_ff        <= clr_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      node_b_ff     <= node_b_in;
      root_a_ff     <= root_a_in;
      size_a_ff     <= size_a_in;
      root_b_ff     <= root_b_in;
      size_b_ff     <= size_b_in;
      res_joined_ff <= res_joined_in;
      res_root_ff   <= res_root_in;
      res_bad_ff    <= res_bad_in;
      rsp_joined_ff <= rsp_joined_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.joined     = rsp_joined_ff;
   assign rsp_bus.root_after = rsp_root_ff;
   assign rsp_bus.components = rsp_comp_ff;
   assign rsp_bus.bad_node   = rsp_bad_ff;

   // Component count stays within 1..node_count
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= ONE_N) && (count_ff <= node_count_ff))
      else $error("component count out of range");

   // Walks only visit nodes in use
   a_walk_node: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIND) || (state_ff == ST_COMP)) |->
      ((cur_ff != '0) && (cur_ff <= node_count_ff)))
      else $error("walk left the node range");

   // A merge links two different roots
   a_merge_roots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW) |-> (small_root != big_root))
      else $error("merge of a root under itself");

   // A bad request reports no join and no root
   a_bad_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (!rsp_joined_ff && (rsp_root_ff == '0)))
      else $error("bad node result carries a join");

   // The component count drops by one on each join
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_GROW) && !csr_bus.valid) |=> (count_ff == $past(count_ff) - ONE_N))
      else $error("component count did not drop on a join");

endmodule
